### rtl/mm_pkg.sv
// Shared types, constants and helper functions for the matrix multiplier.
package mm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int CFG_W       = 4;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int ACC_W       = PROD_W + DIM_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic OP_LEFT  = 1'b0;
    localparam logic OP_RIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CALC,
        ST_WAIT,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic shift;
        logic add;
        logic first;
    } t_ring_ctl;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } t_sat;

    // Map a size register to its effective size minus one.
    function automatic logic [DIM_W-1:0] eff_m1(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (32'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM - 1);
        end else begin
            res = DIM_W'(v - 1'b1);
        end
        return res;
    endfunction

    // Floor shift of the exact sum, then clip to the signed data range.
    function automatic t_sat sat_q(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        t_sat                    res;
        sh = acc >>> FRAC_BITS;
        if (sh[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){sh[ACC_W-1]}}) begin
            res.value = sh[DATA_W-1:0];
            res.sat   = 1'b0;
        end else if (sh[ACC_W-1]) begin
            res.value = {1'b1, {(DATA_W-1){1'b0}}};
            res.sat   = 1'b1;
        end else begin
            res.value = {1'b0, {(DATA_W-1){1'b1}}};
            res.sat   = 1'b1;
        end
        return res;
    endfunction

endpackage

### rtl/mm_if.sv
// Valid/ready channel interfaces for matrix elements in and product elements out.
interface mm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [mm_pkg::DATA_W-1:0] element_value;

    modport source(output valid, output operation, output element_value, input ready);
    modport sink(input valid, input operation, input element_value, output ready);
endinterface

interface mm_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [mm_pkg::DATA_W-1:0] product_value;
    logic                          last_of_run;
    logic                          saturated;

    modport source(output valid, output product_value, output last_of_run,
                   output saturated, input ready);
    modport sink(input valid, input product_value, input last_of_run,
                 input saturated, output ready);
endinterface

### rtl/mm_cell.sv
// One accumulator cell of the rotating accumulator ring.
module mm_cell (
    input  logic                     i_clk,
    input  logic                     i_shift,
    input  logic                     i_clear,
    input  logic                     i_add_en,
    input  logic [mm_pkg::ACC_W-1:0] i_prev,
    input  logic [mm_pkg::ACC_W-1:0] i_add,
    output logic [mm_pkg::ACC_W-1:0] o_acc
);

    logic [mm_pkg::ACC_W-1:0] r_acc;
    logic [mm_pkg::ACC_W-1:0] n_acc;

    always_comb begin
        n_acc = (i_clear ? '0 : i_prev) + (i_add_en ? i_add : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

### rtl/mm_ring.sv
// Chain of accumulator cells closed into a ring of selectable length.
module mm_ring (
    input  logic                     i_clk,
    input  mm_pkg::t_ring_ctl        i_ctl,
    input  logic [mm_pkg::DIM_W-1:0] i_tap_sel,
    input  logic [mm_pkg::PROD_W-1:0] i_prod,
    output logic [mm_pkg::ACC_W-1:0] o_tail
);

    logic [mm_pkg::ACC_W-1:0] w_acc [mm_pkg::MAX_DIM];
    logic [mm_pkg::ACC_W-1:0] w_tap;
    logic [mm_pkg::ACC_W-1:0] w_prod_ext;

    // Close the ring at the cell that holds the first column.
    assign w_tap      = w_acc[i_tap_sel];
    assign w_prod_ext = {{(mm_pkg::ACC_W-mm_pkg::PROD_W){i_prod[mm_pkg::PROD_W-1]}}, i_prod};
    assign o_tail     = w_tap;

    for (genvar m = 0; m < mm_pkg::MAX_DIM; m++) begin : g_cell
        if (m == 0) begin : g_head
            mm_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctl.shift),
                .i_clear (i_ctl.add && i_ctl.first),
                .i_add_en(i_ctl.add),
                .i_prev  (w_tap),
                .i_add   (w_prod_ext),
                .o_acc   (w_acc[m])
            );
        end else begin : g_body
            mm_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctl.shift),
                .i_clear (1'b0),
                .i_add_en(1'b0),
                .i_prev  (w_acc[m-1]),
                .i_add   (w_prod_ext),
                .o_acc   (w_acc[m])
            );
        end
    end

endmodule

### rtl/matrix_multiply.sv
// Top level: element stores, multiplier, accumulator ring and output register.
//
//   channel   direction  payload
//   i_in      in         operation, element_value
//   o_out     out        product_value, last_of_run, saturated
//   i_cfg_*   in         write enable, index (rows_a, inner_dim, cols_b), data
//
// Loading accepts one element per cycle. For each product row, one
// multiplier feeds one multiply-accumulate per cycle into the ring,
// then the row drains. Input ready is high only while loading; a
// held output stalls the drain. Reset is synchronous, active low;
// the stores need no clearing.
module matrix_multiply (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mm_in_if.sink                        i_in,
    mm_out_if.source                     o_out,
    input  logic                         i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mm_pkg::CFG_W-1:0]     i_cfg_data
);

    mm_pkg::t_state r_state;
    mm_pkg::t_state n_state;

    logic [mm_pkg::CFG_W-1:0]  r_rows_a;
    logic [mm_pkg::CFG_W-1:0]  r_inner_dim;
    logic [mm_pkg::CFG_W-1:0]  r_cols_b;
    logic [mm_pkg::CNT_W-1:0]  r_left_count;
    logic [mm_pkg::CNT_W-1:0]  r_right_count;
    logic [mm_pkg::CNT_W-1:0]  n_left_count;
    logic [mm_pkg::CNT_W-1:0]  n_right_count;

    logic [mm_pkg::DIM_W-1:0]  r_rows_m1;
    logic [mm_pkg::DIM_W-1:0]  r_inner_m1;
    logic [mm_pkg::DIM_W-1:0]  r_cols_m1;
    logic [mm_pkg::DIM_W-1:0]  r_i;
    logic [mm_pkg::DIM_W-1:0]  r_j;
    logic [mm_pkg::DIM_W-1:0]  r_k;
    logic [mm_pkg::ADDR_W-1:0] r_a_base;
    logic [mm_pkg::ADDR_W-1:0] r_b_addr;

    logic                      r_rd_v;
    logic                      r_rd_first;
    logic [mm_pkg::DATA_W-1:0] r_a_q;
    logic [mm_pkg::DATA_W-1:0] r_b_q;
    logic                      r_prod_v;
    logic                      r_prod_first;
    logic [mm_pkg::PROD_W-1:0] r_prod;

    logic                      r_out_v;
    logic [mm_pkg::DATA_W-1:0] r_out_value;
    logic                      r_out_last;
    logic                      r_out_sat;

    logic [mm_pkg::DATA_W-1:0] left_mem  [mm_pkg::STORE_DEPTH];
    logic [mm_pkg::DATA_W-1:0] right_mem [mm_pkg::STORE_DEPTH];

    logic [mm_pkg::DIM_W-1:0]  rows_m1_cfg;
    logic [mm_pkg::DIM_W-1:0]  inner_m1_cfg;
    logic [mm_pkg::DIM_W-1:0]  cols_m1_cfg;
    logic [mm_pkg::DIM_W:0]    rows_eff;
    logic [mm_pkg::DIM_W:0]    inner_eff;
    logic [mm_pkg::DIM_W:0]    cols_eff;
    logic [mm_pkg::CNT_W-1:0]  need_a;
    logic [mm_pkg::CNT_W-1:0]  need_b;
    logic                      in_acc;
    logic                      left_we;
    logic                      right_we;
    logic                      stores_full;
    logic [mm_pkg::ADDR_W-1:0] a_addr;

    logic                      in_ready;
    logic                      issue;
    logic                      issue_last;
    logic                      drain_step;
    logic                      row_done;
    mm_pkg::t_ring_ctl         ring_ctl;
    logic [mm_pkg::ACC_W-1:0]  ring_tail;
    mm_pkg::t_sat              sat_res;

    // Sizes and fill tests from the live registers.
    always_comb begin
        rows_m1_cfg  = mm_pkg::eff_m1(r_rows_a);
        inner_m1_cfg = mm_pkg::eff_m1(r_inner_dim);
        cols_m1_cfg  = mm_pkg::eff_m1(r_cols_b);
        rows_eff     = {1'b0, rows_m1_cfg} + 1'b1;
        inner_eff    = {1'b0, inner_m1_cfg} + 1'b1;
        cols_eff     = {1'b0, cols_m1_cfg} + 1'b1;
        need_a       = mm_pkg::CNT_W'(rows_eff) * mm_pkg::CNT_W'(inner_eff);
        need_b       = mm_pkg::CNT_W'(inner_eff) * mm_pkg::CNT_W'(cols_eff);
        in_acc       = i_in.valid && in_ready;
        left_we      = in_acc && (i_in.operation == mm_pkg::OP_LEFT)
                       && (r_left_count < need_a);
        right_we     = in_acc && (i_in.operation == mm_pkg::OP_RIGHT)
                       && (r_right_count < need_b);
        n_left_count  = r_left_count + mm_pkg::CNT_W'(left_we);
        n_right_count = r_right_count + mm_pkg::CNT_W'(right_we);
        stores_full  = (n_left_count >= need_a) && (n_right_count >= need_b);
        a_addr       = r_a_base + mm_pkg::ADDR_W'(r_k);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mm_pkg::ST_LOAD: begin
                if (in_acc && stores_full) begin
                    n_state = mm_pkg::ST_CALC;
                end
            end
            mm_pkg::ST_CALC: begin
                if (issue_last) begin
                    n_state = mm_pkg::ST_WAIT;
                end
            end
            mm_pkg::ST_WAIT: begin
                if (!r_rd_v && !r_prod_v) begin
                    n_state = mm_pkg::ST_DRAIN;
                end
            end
            mm_pkg::ST_DRAIN: begin
                if (row_done) begin
                    n_state = (r_i == r_rows_m1) ? mm_pkg::ST_LOAD : mm_pkg::ST_CALC;
                end
            end
            default: n_state = mm_pkg::ST_LOAD;
        endcase
    end

    // State outputs.
    always_comb begin
        in_ready   = 1'b0;
        issue      = 1'b0;
        drain_step = 1'b0;
        case (r_state)
            mm_pkg::ST_LOAD:  in_ready   = 1'b1;
            mm_pkg::ST_CALC:  issue      = 1'b1;
            mm_pkg::ST_WAIT:  issue      = 1'b0;
            mm_pkg::ST_DRAIN: drain_step = !r_out_v || o_out.ready;
            default:          in_ready   = 1'b0;
        endcase
        issue_last     = issue && (r_j == r_cols_m1) && (r_k == r_inner_m1);
        row_done       = drain_step && (r_j == r_cols_m1);
        ring_ctl.shift = r_prod_v || drain_step;
        ring_ctl.add   = r_prod_v;
        ring_ctl.first = r_prod_first;
    end

    // Configuration, fill counts and sequencing counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= mm_pkg::ST_LOAD;
            r_rows_a      <= mm_pkg::CFG_W'(8);
            r_inner_dim   <= mm_pkg::CFG_W'(8);
            r_cols_b      <= mm_pkg::CFG_W'(8);
            r_left_count  <= '0;
            r_right_count <= '0;
            r_i           <= '0;
            r_j           <= '0;
            r_k           <= '0;
            r_a_base      <= '0;
            r_b_addr      <= '0;
            r_rd_v        <= 1'b0;
            r_prod_v      <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_v   <= issue;
            r_prod_v <= r_rd_v;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mm_pkg::CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                    mm_pkg::CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                    mm_pkg::CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                    default:               r_rows_a    <= r_rows_a;
                endcase
            end
            if (r_state == mm_pkg::ST_LOAD) begin
                if (in_acc && stores_full) begin
                    r_left_count  <= '0;
                    r_right_count <= '0;
                    r_i           <= '0;
                    r_j           <= '0;
                    r_k           <= '0;
                    r_a_base      <= '0;
                    r_b_addr      <= '0;
                end else begin
                    r_left_count  <= n_left_count;
                    r_right_count <= n_right_count;
                end
            end
            if (issue) begin
                r_b_addr <= r_b_addr + 1'b1;
                if (r_j == r_cols_m1) begin
                    r_j <= '0;
                    r_k <= (r_k == r_inner_m1) ? '0 : r_k + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (drain_step) begin
                if (row_done) begin
                    r_j      <= '0;
                    r_i      <= r_i + 1'b1;
                    r_k      <= '0;
                    r_b_addr <= '0;
                    r_a_base <= r_a_base + mm_pkg::ADDR_W'(r_inner_m1)
                                + mm_pkg::ADDR_W'(1);
                end else begin
                    r_j <= r_j + 1'b1;
                end
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Latch the sizes for the whole run.
    always_ff @(posedge i_clk) begin
        if (r_state == mm_pkg::ST_LOAD && in_acc && stores_full) begin
            r_rows_m1  <= rows_m1_cfg;
            r_inner_m1 <= inner_m1_cfg;
            r_cols_m1  <= cols_m1_cfg;
        end
    end

    // Element stores with registered reads.
    always_ff @(posedge i_clk) begin
        if (left_we) begin
            left_mem[r_left_count[mm_pkg::ADDR_W-1:0]] <= i_in.element_value;
        end
        r_a_q <= left_mem[a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (right_we) begin
            right_mem[r_right_count[mm_pkg::ADDR_W-1:0]] <= i_in.element_value;
        end
        r_b_q <= right_mem[r_b_addr];
    end

    // Multiply stage.
    always_ff @(posedge i_clk) begin
        r_rd_first   <= (r_k == '0);
        r_prod_first <= r_rd_first;
        r_prod       <= $signed(r_a_q) * $signed(r_b_q);
    end

    mm_ring u_ring (
        .i_clk    (i_clk),
        .i_ctl    (ring_ctl),
        .i_tap_sel(r_cols_m1),
        .i_prod   (r_prod),
        .o_tail   (ring_tail)
    );

    assign sat_res = mm_pkg::sat_q(ring_tail);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (drain_step) begin
            r_out_value <= sat_res.value;
            r_out_sat   <= sat_res.sat;
            r_out_last  <= (r_i == r_rows_m1) && (r_j == r_cols_m1);
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_v;
    assign o_out.product_value = r_out_value;
    assign o_out.last_of_run   = r_out_last;
    assign o_out.saturated     = r_out_sat;

`ifndef SYNTH
    a_ring_single_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_prod_v && drain_step))
        else $error("ring shifted by product and drain together");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> (!r_rd_v && !r_prod_v))
        else $error("input accepted while multiply pipeline busy");

    a_last_returns_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (row_done && (r_i == r_rows_m1)) |=> (r_state == mm_pkg::ST_LOAD))
        else $error("final product element did not return to loading");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_left_count) <= mm_pkg::STORE_DEPTH)
        && (32'(r_right_count) <= mm_pkg::STORE_DEPTH))
        else $error("load count beyond store depth");
`endif

endmodule
